// ----- rtl/sfte_pkg.sv -----
// Shared types and codes of the strip and fan triangle expander.
`default_nettype none
package sfte_pkg;

  localparam int INDEX_LIMIT_DEFAULT = 2048;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int WORD_W   = 32;
  localparam int VCOUNT_W = 12;
  localparam int IDX_W    = 11;
  localparam int SIDX_W   = 12;
  localparam int KIND_W   = 2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 12'h800;

  localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHORT    = 2'd2;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_SHORT  = 2'd2;
  localparam logic [1:0] OP_VERTEX = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic              fan;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] t;
    logic [SIDX_W-1:0] ix;
  } sfte_op_t;

endpackage
`default_nettype wire

// ----- rtl/sfte_front.sv -----
// Front end: tracks the command stream phase and classifies words into operations.
`default_nettype none
module sfte_front #(
  parameter int INDEX_LIMIT = sfte_pkg::INDEX_LIMIT_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [sfte_pkg::WORD_W-1:0] in_word,
  input  wire logic                          cfg_we,
  input  wire logic [sfte_pkg::VCOUNT_W-1:0] cfg_wdata,
  output logic                               push_valid,
  output sfte_pkg::sfte_op_t                 push_data,
  input  wire logic                          q_full
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_S      = 2'd1;
  localparam logic [1:0] PH_T      = 2'd2;
  localparam logic [1:0] PH_INDEX  = 2'd3;

  logic [1:0]                        phase_r, phase_nxt;
  logic [sfte_pkg::WORD_W-1:0]       left_r, left_nxt;
  logic                              drop_r, drop_nxt;
  logic [sfte_pkg::VCOUNT_W-1:0]     vcount_r, vcount_nxt;
  logic [sfte_pkg::WORD_W-1:0]       pend_s_r, pend_s_nxt;
  logic [sfte_pkg::WORD_W-1:0]       pend_t_r, pend_t_nxt;

  logic [sfte_pkg::WORD_W-1:0] w;
  logic [sfte_pkg::WORD_W-1:0] mag;
  logic                        acc;
  logic                        bad;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign w        = sfte_pkg::WORD_W'(in_word);
  assign mag      = w[sfte_pkg::WORD_W-1] ? (sfte_pkg::WORD_W'(0) - w) : w;
  assign bad      = w[sfte_pkg::WORD_W-1]
                 || (w >= sfte_pkg::WORD_W'(vcount_r))
                 || (w >= sfte_pkg::WORD_W'(INDEX_LIMIT));

  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    drop_nxt   = drop_r;
    pend_s_nxt = pend_s_r;
    pend_t_nxt = pend_t_r;
    vcount_nxt = cfg_we ? cfg_wdata : vcount_r;
    push_valid = 1'b0;
    push_data.op  = sfte_pkg::OP_VERTEX;
    push_data.fan = w[sfte_pkg::WORD_W-1];
    push_data.s   = pend_s_r;
    push_data.t   = pend_t_r;
    push_data.ix  = {bad, w[sfte_pkg::IDX_W-1:0]};
    if (acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          push_valid = 1'b1;
          if (w == '0) begin
            push_data.op = sfte_pkg::OP_END;
          end else begin
            left_nxt  = mag;
            phase_nxt = PH_S;
            if (mag < sfte_pkg::WORD_W'(3)) begin
              push_data.op = sfte_pkg::OP_SHORT;
              drop_nxt     = 1'b1;
            end else begin
              push_data.op = sfte_pkg::OP_START;
              drop_nxt     = 1'b0;
            end
          end
        end
        PH_S: begin
          pend_s_nxt = w;
          phase_nxt  = PH_T;
        end
        PH_T: begin
          pend_t_nxt = w;
          phase_nxt  = PH_INDEX;
        end
        PH_INDEX: begin
          push_valid = !drop_r;
          left_nxt   = left_r - sfte_pkg::WORD_W'(1);
          phase_nxt  = (left_r == sfte_pkg::WORD_W'(1)) ? PH_HEADER : PH_S;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      left_r   <= '0;
      drop_r   <= 1'b0;
      vcount_r <= sfte_pkg::VCOUNT_RESET;
    end else begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      drop_r   <= drop_nxt;
      vcount_r <= vcount_nxt;
    end
    pend_s_r <= pend_s_nxt;
    pend_t_r <= pend_t_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/sfte_queue.sv -----
// Short operation queue between the front end and the triangle builder.
`default_nettype none
module sfte_queue #(
  parameter int DEPTH = sfte_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  input  wire sfte_pkg::sfte_op_t push_data,
  output logic                    full,
  input  wire logic               pop_ready,
  output logic                    pop_valid,
  output sfte_pkg::sfte_op_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfte_pkg::sfte_op_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sfte_back.sv -----
// Triangle builder: keeps the record window and registers one result.
`default_nettype none
module sfte_back (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            op_valid,
  input  wire sfte_pkg::sfte_op_t              op_data,
  output logic                                 op_ready,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [sfte_pkg::KIND_W-1:0]          out_kind,
  output logic [sfte_pkg::WORD_W-1:0]          out_c0_s,
  output logic [sfte_pkg::WORD_W-1:0]          out_c0_t,
  output logic [sfte_pkg::IDX_W-1:0]           out_c0_index,
  output logic [sfte_pkg::WORD_W-1:0]          out_c1_s,
  output logic [sfte_pkg::WORD_W-1:0]          out_c1_t,
  output logic [sfte_pkg::IDX_W-1:0]           out_c1_index,
  output logic [sfte_pkg::WORD_W-1:0]          out_c2_s,
  output logic [sfte_pkg::WORD_W-1:0]          out_c2_t,
  output logic [sfte_pkg::IDX_W-1:0]           out_c2_index,
  output logic                                 out_bad_index
);

  localparam int W  = sfte_pkg::WORD_W;
  localparam int XW = sfte_pkg::SIDX_W;
  localparam int IW = sfte_pkg::IDX_W;

  logic          fan_r, fan_nxt;
  logic [1:0]    ord_r, ord_nxt;
  logic          odd_r, odd_nxt;
  logic          oval_r, oval_nxt;

  logic [W-1:0]  piv_s_r, piv_s_nxt, piv_t_r, piv_t_nxt;
  logic [XW-1:0] piv_x_r, piv_x_nxt;
  logic [W-1:0]  old_s_r, old_s_nxt, old_t_r, old_t_nxt;
  logic [XW-1:0] old_x_r, old_x_nxt;
  logic [W-1:0]  new_s_r, new_s_nxt, new_t_r, new_t_nxt;
  logic [XW-1:0] new_x_r, new_x_nxt;

  logic [sfte_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [W-1:0]  c0s_r, c0s_nxt, c0t_r, c0t_nxt;
  logic [W-1:0]  c1s_r, c1s_nxt, c1t_r, c1t_nxt;
  logic [W-1:0]  c2s_r, c2s_nxt, c2t_r, c2t_nxt;
  logic [XW-1:0] c0x_r, c0x_nxt, c1x_r, c1x_nxt, c2x_r, c2x_nxt;
  logic          bad_r, bad_nxt;

  logic pop;
  logic emit;

  assign op_ready = !oval_r || !out_stall;
  assign pop      = op_valid && op_ready;

  always_comb begin
    fan_nxt   = fan_r;
    ord_nxt   = ord_r;
    odd_nxt   = odd_r;
    piv_s_nxt = piv_s_r;
    piv_t_nxt = piv_t_r;
    piv_x_nxt = piv_x_r;
    old_s_nxt = old_s_r;
    old_t_nxt = old_t_r;
    old_x_nxt = old_x_r;
    new_s_nxt = new_s_r;
    new_t_nxt = new_t_r;
    new_x_nxt = new_x_r;
    emit      = 1'b0;
    kind_nxt  = sfte_pkg::KIND_TRIANGLE;
    c0s_nxt   = '0;
    c0t_nxt   = '0;
    c0x_nxt   = '0;
    c1s_nxt   = '0;
    c1t_nxt   = '0;
    c1x_nxt   = '0;
    c2s_nxt   = '0;
    c2t_nxt   = '0;
    c2x_nxt   = '0;
    bad_nxt   = 1'b0;
    if (pop) begin
      unique case (op_data.op)
        sfte_pkg::OP_START: begin
          fan_nxt = op_data.fan;
          ord_nxt = 2'd0;
          odd_nxt = 1'b0;
        end
        sfte_pkg::OP_END: begin
          emit     = 1'b1;
          kind_nxt = sfte_pkg::KIND_END;
        end
        sfte_pkg::OP_SHORT: begin
          emit     = 1'b1;
          kind_nxt = sfte_pkg::KIND_SHORT;
        end
        sfte_pkg::OP_VERTEX: begin
          case (ord_r)
            2'd0: begin
              if (fan_r) begin
                piv_s_nxt = op_data.s;
                piv_t_nxt = op_data.t;
                piv_x_nxt = op_data.ix;
              end else begin
                old_s_nxt = op_data.s;
                old_t_nxt = op_data.t;
                old_x_nxt = op_data.ix;
              end
              ord_nxt = 2'd1;
            end
            2'd1: begin
              new_s_nxt = op_data.s;
              new_t_nxt = op_data.t;
              new_x_nxt = op_data.ix;
              ord_nxt   = 2'd2;
            end
            default: begin
              emit = 1'b1;
              if (fan_r) begin
                c0s_nxt = piv_s_r;
                c0t_nxt = piv_t_r;
                c0x_nxt = piv_x_r;
                c1s_nxt = new_s_r;
                c1t_nxt = new_t_r;
                c1x_nxt = new_x_r;
              end else if (odd_r) begin
                c0s_nxt = new_s_r;
                c0t_nxt = new_t_r;
                c0x_nxt = new_x_r;
                c1s_nxt = old_s_r;
                c1t_nxt = old_t_r;
                c1x_nxt = old_x_r;
              end else begin
                c0s_nxt = old_s_r;
                c0t_nxt = old_t_r;
                c0x_nxt = old_x_r;
                c1s_nxt = new_s_r;
                c1t_nxt = new_t_r;
                c1x_nxt = new_x_r;
              end
              c2s_nxt = op_data.s;
              c2t_nxt = op_data.t;
              c2x_nxt = op_data.ix;
              bad_nxt = c0x_nxt[XW-1] | c1x_nxt[XW-1] | op_data.ix[XW-1];
              if (!fan_r) begin
                old_s_nxt = new_s_r;
                old_t_nxt = new_t_r;
                old_x_nxt = new_x_r;
                odd_nxt   = !odd_r;
              end
              new_s_nxt = op_data.s;
              new_t_nxt = op_data.t;
              new_x_nxt = op_data.ix;
            end
          endcase
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    if (pop && emit) begin
      oval_nxt = 1'b1;
    end else if (oval_r && !out_stall) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_r  <= 1'b0;
      ord_r  <= 2'd0;
      odd_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      fan_r  <= fan_nxt;
      ord_r  <= ord_nxt;
      odd_r  <= odd_nxt;
      oval_r <= oval_nxt;
    end
    piv_s_r <= piv_s_nxt;
    piv_t_r <= piv_t_nxt;
    piv_x_r <= piv_x_nxt;
    old_s_r <= old_s_nxt;
    old_t_r <= old_t_nxt;
    old_x_r <= old_x_nxt;
    new_s_r <= new_s_nxt;
    new_t_r <= new_t_nxt;
    new_x_r <= new_x_nxt;
    if (pop && emit) begin
      kind_r <= kind_nxt;
      c0s_r  <= c0s_nxt;
      c0t_r  <= c0t_nxt;
      c0x_r  <= c0x_nxt;
      c1s_r  <= c1s_nxt;
      c1t_r  <= c1t_nxt;
      c1x_r  <= c1x_nxt;
      c2s_r  <= c2s_nxt;
      c2t_r  <= c2t_nxt;
      c2x_r  <= c2x_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid     = oval_r;
  assign out_kind      = kind_r;
  assign out_c0_s      = c0s_r;
  assign out_c0_t      = c0t_r;
  assign out_c0_index  = c0x_r[IW-1:0];
  assign out_c1_s      = c1s_r;
  assign out_c1_t      = c1t_r;
  assign out_c1_index  = c1x_r[IW-1:0];
  assign out_c2_s      = c2s_r;
  assign out_c2_t      = c2t_r;
  assign out_c2_index  = c2x_r[IW-1:0];
  assign out_bad_index = bad_r;

endmodule
`default_nettype wire

// ----- rtl/strip_fan_triangle_expander.sv -----
// Top level of the strip and fan to triangle list expander.
// Takes one 32-bit command word per cycle while in_stall is low and gives at most one result
// per word: a triangle, an end-of-list marker or a short-run marker. The front end follows the
// header, s, t and index phases and pushes one operation per header word and per index word of
// a non-short run into a small queue (QUEUE_DEPTH entries); the builder pops one operation per
// cycle unless out_stall holds its result register, and registers the result. While out_stall
// is low the sustained rate is one word per cycle. Input stall rises only when the queue is
// full, which happens only after the result register has been stalled. vertex_count is written
// through cfg_we/cfg_wdata and resets to 2048.
`default_nettype none
module strip_fan_triangle_expander #(
  parameter int INDEX_LIMIT = sfte_pkg::INDEX_LIMIT_DEFAULT,
  parameter int QUEUE_DEPTH = sfte_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [sfte_pkg::WORD_W-1:0]   in_word,
  input  wire logic                                 cfg_we,
  input  wire logic [sfte_pkg::VCOUNT_W-1:0]        cfg_wdata,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [sfte_pkg::KIND_W-1:0]               out_kind,
  output logic [sfte_pkg::WORD_W-1:0]               out_c0_s,
  output logic [sfte_pkg::WORD_W-1:0]               out_c0_t,
  output logic [sfte_pkg::IDX_W-1:0]                out_c0_index,
  output logic [sfte_pkg::WORD_W-1:0]               out_c1_s,
  output logic [sfte_pkg::WORD_W-1:0]               out_c1_t,
  output logic [sfte_pkg::IDX_W-1:0]                out_c1_index,
  output logic [sfte_pkg::WORD_W-1:0]               out_c2_s,
  output logic [sfte_pkg::WORD_W-1:0]               out_c2_t,
  output logic [sfte_pkg::IDX_W-1:0]                out_c2_index,
  output logic                                      out_bad_index
);

  logic               push_valid;
  sfte_pkg::sfte_op_t push_data;
  logic               q_full;
  logic               op_valid;
  logic               op_ready;
  sfte_pkg::sfte_op_t op_data;

  sfte_front #(
    .INDEX_LIMIT (INDEX_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  sfte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_ready  (op_ready),
    .pop_valid  (op_valid),
    .pop_data   (op_data)
  );

  sfte_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (op_valid),
    .op_data       (op_data),
    .op_ready      (op_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_c0_s      (out_c0_s),
    .out_c0_t      (out_c0_t),
    .out_c0_index  (out_c0_index),
    .out_c1_s      (out_c1_s),
    .out_c1_t      (out_c1_t),
    .out_c1_index  (out_c1_index),
    .out_c2_s      (out_c2_s),
    .out_c2_t      (out_c2_t),
    .out_c2_index  (out_c2_index),
    .out_bad_index (out_bad_index)
  );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the strip and fan triangle expander.
`timescale 1ns / 100ps

module tb;

  localparam int WORD_W = sfte_pkg::WORD_W;
  localparam int SIDX_W = sfte_pkg::SIDX_W;
  localparam int IDX_W = sfte_pkg::IDX_W;
  localparam int KIND_W = sfte_pkg::KIND_W;
  localparam int VCOUNT_W = sfte_pkg::VCOUNT_W;
  localparam int INDEX_LIMIT_DEFAULT = sfte_pkg::INDEX_LIMIT_DEFAULT;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = sfte_pkg::VCOUNT_RESET;
  localparam logic [KIND_W-1:0] KIND_TRIANGLE = sfte_pkg::KIND_TRIANGLE;
  localparam logic [KIND_W-1:0] KIND_END = sfte_pkg::KIND_END;
  localparam logic [KIND_W-1:0] KIND_SHORT = sfte_pkg::KIND_SHORT;

  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_WORDS = 190;
  localparam logic [WORD_W-1:0] INDEX_CAP = INDEX_LIMIT_DEFAULT;

  typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_S, AWAIT_T, AWAIT_INDEX} parse_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] t;
    logic [SIDX_W-1:0] ix;
  } corner_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] c0_s;
    logic [WORD_W-1:0] c0_t;
    logic [IDX_W-1:0]  c0_index;
    logic [WORD_W-1:0] c1_s;
    logic [WORD_W-1:0] c1_t;
    logic [IDX_W-1:0]  c1_index;
    logic [WORD_W-1:0] c2_s;
    logic [WORD_W-1:0] c2_t;
    logic [IDX_W-1:0]  c2_index;
    logic              bad_index;
  } prim_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    bit                typed;
    logic [KIND_W-1:0] kind;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [WORD_W-1:0] in_word = '0;
  logic cfg_we = 1'b0;
  logic [VCOUNT_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] out_kind;
  logic [WORD_W-1:0] out_c0_s, out_c0_t, out_c1_s, out_c1_t, out_c2_s, out_c2_t;
  logic [IDX_W-1:0] out_c0_index, out_c1_index, out_c2_index;
  logic out_bad_index;

  parse_state_t parse_state = AWAIT_HEADER;
  logic fan_run = 1'b0;
  logic [WORD_W-1:0] run_left = '0;
  logic [1:0] rec_count = '0;
  logic odd_turn = 1'b0;
  logic [WORD_W-1:0] held_s = '0, held_t = '0;
  corner_t pivot_c = '0, trail_c = '0, lead_c = '0;
  logic [VCOUNT_W-1:0] vcount_cfg = VCOUNT_RESET;

  prim_t due_prims[$];
  int unsigned prims_pushed = 0;
  int unsigned prim_errors = 0;
  int unsigned words_sent = 0;
  int unsigned in_gap_max = 12;
  int unsigned out_gap_max = 12;
  bit long_hold_req = 1'b0;

  cmd_row_t opening_cmds[28] = '{
    '{32'h0000_0000, 1'b1, KIND_END},
    '{32'hFFFF_FFFF, 1'b1, KIND_SHORT},
    '{32'hFFFF_FFFF, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0005, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0004, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0000, 1'b0, KIND_TRIANGLE},
    '{32'hFFFF_FFFF, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h8000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h7FFF_FFFF, 1'b0, KIND_TRIANGLE},
    '{32'h0000_07FF, 1'b0, KIND_TRIANGLE},
    '{32'h7FFF_FFFF, 1'b0, KIND_TRIANGLE},
    '{32'h8000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h8000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h1234_5678, 1'b0, KIND_TRIANGLE},
    '{32'h9ABC_DEF0, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0800, 1'b0, KIND_TRIANGLE},
    '{32'hFFFF_FFFD, 1'b0, KIND_TRIANGLE},
    '{32'h3F80_0000, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0007, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0000, 1'b0, KIND_TRIANGLE},
    '{32'h3F80_0000, 1'b0, KIND_TRIANGLE},
    '{32'h0000_0008, 1'b0, KIND_TRIANGLE},
    '{32'h3F00_0000, 1'b0, KIND_TRIANGLE},
    '{32'h3F00_0000, 1'b0, KIND_TRIANGLE},
    '{32'h7FFF_FFFF, 1'b0, KIND_TRIANGLE}
  };

  logic [VCOUNT_W-1:0] vcount_steps[8] = '{
    12'd1, 12'd4095, 12'd0, 12'd3, 12'd2047, 12'd2048, 12'd2048, 12'd12
  };

  strip_fan_triangle_expander dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_c0_s     (out_c0_s),
    .out_c0_t     (out_c0_t),
    .out_c0_index (out_c0_index),
    .out_c1_s     (out_c1_s),
    .out_c1_t     (out_c1_t),
    .out_c1_index (out_c1_index),
    .out_c2_s     (out_c2_s),
    .out_c2_t     (out_c2_t),
    .out_c2_index (out_c2_index),
    .out_bad_index(out_bad_index)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void expand_word(logic [WORD_W-1:0] w);
    prim_t p;
    corner_t cur, a, b;
    logic [WORD_W-1:0] mag;
    logic bad;
    p = '0;
    case (parse_state)
      AWAIT_HEADER: begin
        mag = w[WORD_W-1] ? -w : w;
        if (w == '0) begin
          p.kind = KIND_END;
          due_prims.push_back(p);
          prims_pushed++;
        end else begin
          fan_run = w[WORD_W-1];
          run_left = mag;
          rec_count = '0;
          odd_turn = 1'b0;
          parse_state = AWAIT_S;
          if (mag < 3) begin
            p.kind = KIND_SHORT;
            due_prims.push_back(p);
            prims_pushed++;
          end
        end
      end
      AWAIT_S: begin
        held_s = w;
        parse_state = AWAIT_T;
      end
      AWAIT_T: begin
        held_t = w;
        parse_state = AWAIT_INDEX;
      end
      default: begin
        bad = w[WORD_W-1] || (w >= WORD_W'(vcount_cfg)) || (w >= INDEX_CAP);
        cur.s = held_s;
        cur.t = held_t;
        cur.ix = {bad, w[IDX_W-1:0]};
        case (rec_count)
          2'd0: begin
            if (fan_run) pivot_c = cur;
            else trail_c = cur;
            rec_count = 2'd1;
          end
          2'd1: begin
            lead_c = cur;
            rec_count = 2'd2;
          end
          default: begin
            if (fan_run) begin
              a = pivot_c;
              b = lead_c;
            end else if (odd_turn) begin
              a = lead_c;
              b = trail_c;
            end else begin
              a = trail_c;
              b = lead_c;
            end
            p.kind = KIND_TRIANGLE;
            p.c0_s = a.s;
            p.c0_t = a.t;
            p.c0_index = a.ix[IDX_W-1:0];
            p.c1_s = b.s;
            p.c1_t = b.t;
            p.c1_index = b.ix[IDX_W-1:0];
            p.c2_s = cur.s;
            p.c2_t = cur.t;
            p.c2_index = cur.ix[IDX_W-1:0];
            p.bad_index = a.ix[SIDX_W-1] | b.ix[SIDX_W-1] | cur.ix[SIDX_W-1];
            if (!fan_run) begin
              trail_c = lead_c;
              odd_turn = ~odd_turn;
            end
            lead_c = cur;
            due_prims.push_back(p);
            prims_pushed++;
          end
        endcase
        run_left = run_left - 1;
        parse_state = (run_left == '0) ? AWAIT_HEADER : AWAIT_S;
      end
    endcase
  endfunction

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got,
                              inout int unsigned nbad);
    if (want !== got) begin
      if (prim_errors < 10) $display("mismatch %s: expected %0h, got %0h", name, want, got);
      nbad++;
    end
  endfunction

  task automatic check_prim();
    prim_t want;
    int unsigned nbad;
    nbad = 0;
    if (due_prims.size() == 0) begin
      if (prim_errors < 10) $display("mismatch: unexpected result of kind %0d", out_kind);
      prim_errors++;
      return;
    end
    want = due_prims.pop_front();
    cmp("kind", want.kind, out_kind, nbad);
    cmp("c0_s", want.c0_s, out_c0_s, nbad);
    cmp("c0_t", want.c0_t, out_c0_t, nbad);
    cmp("c0_index", want.c0_index, out_c0_index, nbad);
    cmp("c1_s", want.c1_s, out_c1_s, nbad);
    cmp("c1_t", want.c1_t, out_c1_t, nbad);
    cmp("c1_index", want.c1_index, out_c1_index, nbad);
    cmp("c2_s", want.c2_s, out_c2_s, nbad);
    cmp("c2_t", want.c2_t, out_c2_t, nbad);
    cmp("c2_index", want.c2_index, out_c2_index, nbad);
    cmp("bad_index", want.bad_index, out_bad_index, nbad);
    if (nbad != 0) prim_errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_prim();
  end

  initial begin
    int unsigned hold;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      hold = $urandom_range(0, out_gap_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_word(logic [WORD_W-1:0] w);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    expand_word(w);
    words_sent++;
  endtask

  function automatic logic [WORD_W-1:0] pick_index();
    int unsigned sel, lim;
    sel = $urandom_range(0, 99);
    lim = (vcount_cfg > INDEX_LIMIT_DEFAULT) ? INDEX_LIMIT_DEFAULT : vcount_cfg;
    if (sel < 70) return (lim == 0) ? $urandom_range(0, 100) : $urandom_range(0, lim - 1);
    if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: return WORD_W'(vcount_cfg) - 1;
        1: return WORD_W'(vcount_cfg);
        2: return INDEX_CAP - 1;
        default: return INDEX_CAP;
      endcase
    end
    if (sel < 90) return $urandom;
    return $urandom_range(0, 4095);
  endfunction

  task automatic send_record();
    send_word($urandom);
    send_word($urandom);
    send_word(pick_index());
  endtask

  task automatic send_run();
    int unsigned sel, mag;
    logic [WORD_W-1:0] hdr;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      send_word('0);
      return;
    end
    if (sel < 13) mag = $urandom_range(1, 2);
    else if (sel < 18) mag = $urandom_range(20, 48);
    else mag = $urandom_range(3, 9);
    hdr = mag;
    if ($urandom_range(0, 1) == 1) hdr = -hdr;
    send_word(hdr);
    repeat (mag) send_record();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_prims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vcount(logic [VCOUNT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount_cfg = v;
  endtask

  initial begin
    prim_t p;
    int unsigned before_cnt, start_cnt;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_cmds[i]) begin
      before_cnt = prims_pushed;
      send_word(opening_cmds[i].word);
      if (opening_cmds[i].typed) begin
        if (prims_pushed > before_cnt) void'(due_prims.pop_back());
        p = '0;
        p.kind = opening_cmds[i].kind;
        due_prims.push_back(p);
      end
    end
    settle();

    vcount_steps[6] = VCOUNT_W'($urandom_range(1, 2048));
    foreach (vcount_steps[k]) begin
      case (k)
        2: begin
          in_gap_max = 0;
          out_gap_max = 0;
        end
        4: begin
          in_gap_max = 0;
          out_gap_max = 12;
        end
        5: begin
          in_gap_max = 12;
          out_gap_max = 0;
        end
        default: begin
          in_gap_max = 12;
          out_gap_max = 12;
        end
      endcase
      write_vcount(vcount_steps[k]);
      if (k == 4) long_hold_req = 1'b1;
      start_cnt = words_sent;
      while (words_sent - start_cnt < PHASE_WORDS) send_run();
      settle();
    end

    // most negative header: a fan whose run does not end within the records sent
    in_gap_max = 12;
    out_gap_max = 12;
    send_word(32'h8000_0000);
    repeat (6) send_record();
    settle();

    prim_errors += due_prims.size();
    if (prim_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
